// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising clock edge, ignored while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("concurrent assertion failed");

// Checked at each rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("concurrent assertion failed");

`endif

// File: rtl/tets_pkg.sv
// ----------------------------------------------------------------------------
// Text style escape tracker package
// Item types, style code bytes and fixed widths shared by the design files.
// ----------------------------------------------------------------------------
package tets_pkg;

   localparam int PAIR_W   = 4;
   localparam int NUM_ATTR = 5;
   localparam int NUM_NEST = 6;
   localparam int NEST_OVR = 5;

   localparam logic [PAIR_W-1:0] MAX_PAIR = 4'd8;

   // Attribute positions in the shown attribute vector.
   localparam int ATTR_BOLD      = 0;
   localparam int ATTR_UNDERLINE = 1;
   localparam int ATTR_STANDOUT  = 2;
   localparam int ATTR_REVERSE   = 3;
   localparam int ATTR_DIM       = 4;

   // Style code bytes.
   localparam logic [7:0] CODE_BOLD_ON       = 8'h42; // B
   localparam logic [7:0] CODE_BOLD_OFF      = 8'h62; // b
   localparam logic [7:0] CODE_UNDERLINE_ON  = 8'h55; // U
   localparam logic [7:0] CODE_UNDERLINE_OFF = 8'h75; // u
   localparam logic [7:0] CODE_STANDOUT_ON   = 8'h53; // S
   localparam logic [7:0] CODE_STANDOUT_OFF  = 8'h73; // s
   localparam logic [7:0] CODE_REVERSE_ON    = 8'h52; // R
   localparam logic [7:0] CODE_REVERSE_OFF   = 8'h72; // r
   localparam logic [7:0] CODE_DIM_ON        = 8'h44; // D
   localparam logic [7:0] CODE_DIM_OFF       = 8'h64; // d
   localparam logic [7:0] CODE_NORMAL_ON     = 8'h4E; // N
   localparam logic [7:0] CODE_NORMAL_OFF    = 8'h6E; // n
   localparam logic [7:0] CODE_CLEAR         = 8'h43; // C
   localparam logic [7:0] CODE_POP           = 8'h30; // 0
   localparam logic [7:0] CODE_PAIR_FIRST    = 8'h31; // 1
   localparam logic [7:0] CODE_PAIR_LAST     = 8'h38; // 8

   typedef struct packed {
      logic [7:0] style_code;
   } req_type;

   typedef struct packed {
      logic              bold;
      logic              underline;
      logic              standout;
      logic              reverse_video;
      logic              dim;
      logic [PAIR_W-1:0] pair_id;
   } rsp_type;

   // Command from the decoder to the color stack.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [PAIR_W-1:0] pair;
   } stack_cmd_type;

endpackage

// File: rtl/tets_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tets_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tets_color_stack.sv
// ----------------------------------------------------------------------------
// Color pair stack
// Bounded stack of color pairs that drops its oldest entry on overflow.
// ----------------------------------------------------------------------------
module tets_color_stack #(
   parameter int COLOR_DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tets_pkg::stack_cmd_type     cmd,
   output logic [tets_pkg::PAIR_W-1:0] color
);
   localparam int IDX_W = $clog2(COLOR_DEPTH);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(COLOR_DEPTH - 1);
   localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

   logic [tets_pkg::PAIR_W-1:0] stack_ff [COLOR_DEPTH];
   logic [tets_pkg::PAIR_W-1:0] stack_in [COLOR_DEPTH];
   logic [IDX_W-1:0]            idx_ff;
   logic [IDX_W-1:0]            idx_in;
   logic [IDX_W-1:0]            below_idx;

   always_comb begin
      stack_in  = stack_ff;
      idx_in    = idx_ff;
      color     = '0;
      below_idx = '0;
      if (cmd.push) begin
         if (idx_ff == TOP_IDX) begin
            // A full stack slides down and loses its oldest pair.
            if (stack_ff[COLOR_DEPTH-1] != '0) begin
               for (int k = 0; k < COLOR_DEPTH - 1; k++) begin
                  stack_in[k] = stack_ff[k+1];
               end
            end
            stack_in[COLOR_DEPTH-1] = cmd.pair;
         end else begin
            stack_in[idx_ff] = cmd.pair;
            idx_in           = idx_ff + ONE_IDX;
         end
         color = cmd.pair;
      end else if (cmd.pop) begin
         if (idx_ff != TOP_IDX || stack_ff[COLOR_DEPTH-1] == '0) begin
            idx_in = (idx_ff > ONE_IDX) ? idx_ff - ONE_IDX : ONE_IDX;
         end
         below_idx        = idx_in - ONE_IDX;
         stack_in[idx_in] = '0;
         color            = stack_ff[below_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int k = 0; k < COLOR_DEPTH; k++) begin
            stack_ff[k] <= '0;
         end
      end else begin
         idx_ff   <= idx_in;
         stack_ff <= stack_in;
      end
   end
endmodule

// File: rtl/text_style_escape_tracker.sv
// ----------------------------------------------------------------------------
// Text style escape tracker
// Follows inline style codes and reports the shown attributes and color pair.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register stage, and its result is then
// offered from the result register.
// Throughput: one item per cycle while the output is not stalled; the decode and update are combinational.
// The result register holds the shown state, so a stalled output stalls input.
// Synchronous reset clears the counters, the color stack and the shown state,
// and drops any item in flight.
module text_style_escape_tracker #(
   parameter int COLOR_DEPTH = 8,
   parameter int COUNT_WIDTH = 8
) (
   input logic         clock,
   input logic         reset,
   tets_stream_if.sink   req_ch,
   tets_stream_if.source rsp_ch
);
   // Input register stage: holds one code until the result register is free.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_code_ff;
   logic       s1_go;

   // Nesting counters: five attributes and the normal override.
   logic [COUNT_WIDTH-1:0] cnt_ff [tets_pkg::NUM_NEST];
   logic [COUNT_WIDTH-1:0] cnt_in [tets_pkg::NUM_NEST];

   // Shown state doubles as the result register.
   logic [tets_pkg::NUM_ATTR-1:0] attr_ff;
   logic [tets_pkg::NUM_ATTR-1:0] attr_in;
   logic [tets_pkg::PAIR_W-1:0]   color_ff;
   logic [tets_pkg::PAIR_W-1:0]   color_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   // Decoded code.
   logic [tets_pkg::NUM_ATTR-1:0] attr_sel;
   logic                          attr_up;
   logic                          norm_on;
   logic                          norm_off;
   logic                          clear_all;
   tets_pkg::stack_cmd_type       stack_cmd;
   logic [tets_pkg::PAIR_W-1:0]   stack_color;
   logic [COUNT_WIDTH-1:0]        ovr_dec;

   // The input stage moves on whenever the result register is empty or its
   // item is being taken in this cycle.
   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in  = (req_ch.valid && req_ch.ready) || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ch.ready);

   // Code decode. Upper-case and lower-case letters of one attribute differ
   // only in bit 5, which tells an increment from a decrement.
   always_comb begin
      attr_sel       = '0;
      norm_on        = 1'b0;
      norm_off       = 1'b0;
      clear_all      = 1'b0;
      stack_cmd      = '0;
      stack_cmd.pair = s1_code_ff[tets_pkg::PAIR_W-1:0];
      unique case (s1_code_ff) inside
         tets_pkg::CODE_BOLD_ON, tets_pkg::CODE_BOLD_OFF: begin
            attr_sel[tets_pkg::ATTR_BOLD] = 1'b1;
         end
         tets_pkg::CODE_UNDERLINE_ON, tets_pkg::CODE_UNDERLINE_OFF: begin
            attr_sel[tets_pkg::ATTR_UNDERLINE] = 1'b1;
         end
         tets_pkg::CODE_STANDOUT_ON, tets_pkg::CODE_STANDOUT_OFF: begin
            attr_sel[tets_pkg::ATTR_STANDOUT] = 1'b1;
         end
         tets_pkg::CODE_REVERSE_ON, tets_pkg::CODE_REVERSE_OFF: begin
            attr_sel[tets_pkg::ATTR_REVERSE] = 1'b1;
         end
         tets_pkg::CODE_DIM_ON, tets_pkg::CODE_DIM_OFF: begin
            attr_sel[tets_pkg::ATTR_DIM] = 1'b1;
         end
         tets_pkg::CODE_NORMAL_ON: begin
            norm_on = 1'b1;
         end
         tets_pkg::CODE_NORMAL_OFF: begin
            norm_off = 1'b1;
         end
         tets_pkg::CODE_CLEAR: begin
            clear_all = 1'b1;
         end
         tets_pkg::CODE_POP: begin
            stack_cmd.pop = s1_go;
         end
         [tets_pkg::CODE_PAIR_FIRST:tets_pkg::CODE_PAIR_LAST]: begin
            stack_cmd.push = s1_go;
         end
         default: begin
         end
      endcase
   end

   assign attr_up = !s1_code_ff[5];
   assign ovr_dec = cnt_ff[tets_pkg::NEST_OVR] - COUNT_WIDTH'(1);

   // The color stack updates on push and pop and reports the new color.
   tets_color_stack #(
      .COLOR_DEPTH (COLOR_DEPTH)
   ) u_color_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .color (stack_color)
   );

   // Counter and shown state update for the code in the input stage.
   always_comb begin
      cnt_in   = cnt_ff;
      attr_in  = attr_ff;
      color_in = color_ff;
      if (s1_go) begin
         for (int k = 0; k < tets_pkg::NUM_ATTR; k++) begin
            if (attr_sel[k]) begin
               if (attr_up) begin
                  // Shown unless the normal override is in force.
                  cnt_in[k] = cnt_ff[k] + COUNT_WIDTH'(1);
                  if (cnt_ff[tets_pkg::NEST_OVR] == '0) begin
                     attr_in[k] = 1'b1;
                  end
               end else begin
                  // A decrement from zero wraps to all ones and hides nothing.
                  cnt_in[k] = cnt_ff[k] - COUNT_WIDTH'(1);
                  if (cnt_in[k] == '0) begin
                     attr_in[k] = 1'b0;
                  end
               end
            end
         end
         if (norm_on) begin
            cnt_in[tets_pkg::NEST_OVR] = cnt_ff[tets_pkg::NEST_OVR] + COUNT_WIDTH'(1);
            attr_in  = '0;
            color_in = '0;
         end
         if (norm_off) begin
            // Leaving the override brings back every attribute still nested.
            cnt_in[tets_pkg::NEST_OVR] = ovr_dec;
            if (ovr_dec == '0) begin
               for (int k = 0; k < tets_pkg::NUM_ATTR; k++) begin
                  if (cnt_ff[k] != '0) begin
                     attr_in[k] = 1'b1;
                  end
               end
            end
         end
         if (clear_all) begin
            // The override count survives a clear.
            for (int k = 0; k < tets_pkg::NUM_ATTR; k++) begin
               cnt_in[k] = '0;
            end
            attr_in  = '0;
            color_in = '0;
         end
         if (stack_cmd.push || stack_cmd.pop) begin
            color_in = stack_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= '0;
         color_ff     <= '0;
         for (int k = 0; k < tets_pkg::NUM_NEST; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         attr_ff      <= attr_in;
         color_ff     <= color_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_code_ff <= req_ch.data.style_code;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.data.bold          = attr_ff[tets_pkg::ATTR_BOLD];
   assign rsp_ch.data.underline     = attr_ff[tets_pkg::ATTR_UNDERLINE];
   assign rsp_ch.data.standout      = attr_ff[tets_pkg::ATTR_STANDOUT];
   assign rsp_ch.data.reverse_video = attr_ff[tets_pkg::ATTR_REVERSE];
   assign rsp_ch.data.dim           = attr_ff[tets_pkg::ATTR_DIM];
   assign rsp_ch.data.pair_id       = color_ff;
endmodule

// File: rtl/tets_checker.sv
// ----------------------------------------------------------------------------
// Text style escape tracker checker
// Port-level assertions on the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tets_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tets_pkg::rsp_type rsp_data
);
   // A stalled result stays offered and unchanged.
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLKD(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data))

   // Only pairs 1 to 8 and the default ever reach the stack.
   `ASSERT_CLKD(a_pair_range, clock, reset, rsp_valid |-> rsp_data.pair_id <= tets_pkg::MAX_PAIR)

   // With the result register empty the input side always has room.
   `ASSERT_CLKD(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // Reset drops any result in flight.
   `ASSERT_CLK(a_reset_flush, clock, reset |=> !rsp_valid)
endmodule

bind text_style_escape_tracker tets_checker u_tets_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
